FILE: design/skfp_pkg.sv
package skfp_pkg;

    // Parse phases; each code equals the byte role reported for that phase
    localparam logic [3:0] PH_NAMELEN  = 4'd0;
    localparam logic [3:0] PH_NAME     = 4'd1;
    localparam logic [3:0] PH_TYPE     = 4'd2;
    localparam logic [3:0] PH_ELEMLEN  = 4'd3;
    localparam logic [3:0] PH_ELEM     = 4'd4;
    localparam logic [3:0] PH_ACTORLEN = 4'd5;
    localparam logic [3:0] PH_ACTOR    = 4'd6;
    localparam logic [3:0] PH_COUNTER  = 4'd7;
    localparam logic [3:0] PH_IGNORED  = 4'd8;

    // Key type codes
    localparam logic [2:0] TYPE_NONE      = 3'd0;
    localparam logic [2:0] TYPE_CLOCK     = 3'd1;
    localparam logic [2:0] TYPE_TOMBSTONE = 3'd2;
    localparam logic [2:0] TYPE_ELEMENT   = 3'd3;
    localparam logic [2:0] TYPE_END       = 3'd4;
    localparam logic [2:0] TYPE_INVALID   = 3'd5;

    // Type byte values
    localparam logic [7:0] CHAR_CLOCK     = 8'h63;
    localparam logic [7:0] CHAR_TOMBSTONE = 8'h64;
    localparam logic [7:0] CHAR_ELEMENT   = 8'h65;
    localparam logic [7:0] CHAR_END       = 8'h7a;

    localparam int unsigned RESULT_W = 200;

    typedef logic [RESULT_W-1:0] result_t;

endpackage

FILE: design/set_key_field_parser.sv
// Stored-key field parser.
// Slave channel (s_*): one key byte per transfer in s_tdata, s_tlast on the
// final byte of a key. Master channel (m_*): one result per key byte giving
// the byte's role and offset within its field and the key type seen so far;
// m_tlast marks the result of the key's last byte, which also carries the
// status, the decoded lengths and the counter (these are zero otherwise).
// An accepted byte reaches its result on m_* through an input register and a
// result register. Throughput: one byte per cycle while the receiver does not
// stall; the single phase update between the two registers sets that figure.
// When the receiver stalls, the result register holds and the input register
// takes one more byte before s_tready drops.
// Reset (aresetn low, synchronous) empties both registers and returns the
// parser to the start of a key; after each last byte it also starts afresh.
module set_key_field_parser
    import skfp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] key_byte
    input  logic                s_tlast,   // key_last
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [RESULT_W-1:0] m_tdata,   // [3:0] byte_role, [35:4] byte_offset,
                                           // [38:36] key_type, [39] key_status,
                                           // [71:40] name_length,
                                           // [103:72] element_length,
                                           // [135:104] actor_length,
                                           // [199:136] counter_value
    output logic                m_tlast    // key_done
);

    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    logic        out_vld_reg;
    result_t     out_data_reg;
    logic        out_last_reg;

    logic [3:0]  phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] flen_reg, flen_next;
    logic [63:0] cnt_reg, cnt_next;
    logic [2:0]  type_reg, type_next;
    logic [31:0] nlen_reg, nlen_next;
    logic [31:0] elen_reg, elen_next;
    logic [31:0] alen_reg, alen_next;

    logic        out_free;
    logic        move;
    logic [3:0]  ph;
    logic [4:0]  len_sh;
    logic [5:0]  cnt_sh;
    logic [31:0] byte_w;
    logic        complete;
    result_t     result;

    assign out_free = !out_vld_reg || m_tready;
    assign move     = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        flen_next  = flen_reg;
        cnt_next   = cnt_reg;
        type_next  = type_reg;
        nlen_next  = nlen_reg;
        elen_next  = elen_reg;
        alen_next  = alen_reg;

        ph       = (phase_reg > PH_IGNORED) ? PH_IGNORED : phase_reg;
        len_sh   = {pos_reg[1:0], 3'b000};
        cnt_sh   = {pos_reg[2:0], 3'b000};
        byte_w   = {24'd0, in_byte_reg};
        if (phase_reg > PH_IGNORED) begin
            phase_next = PH_IGNORED;
        end

        case (ph)
            PH_NAMELEN: begin
                nlen_next = nlen_reg | (byte_w << len_sh);
                if (pos_reg >= 32'd3) begin
                    pos_next   = '0;
                    flen_next  = nlen_next;
                    phase_next = (nlen_next == '0) ? PH_TYPE : PH_NAME;
                end else begin
                    pos_next = pos_reg + 32'd1;
                end
            end
            PH_ELEMLEN: begin
                elen_next = elen_reg | (byte_w << len_sh);
                if (pos_reg >= 32'd3) begin
                    pos_next   = '0;
                    flen_next  = elen_next;
                    phase_next = (elen_next == '0) ? PH_ACTORLEN : PH_ELEM;
                end else begin
                    pos_next = pos_reg + 32'd1;
                end
            end
            PH_ACTORLEN: begin
                alen_next = alen_reg | (byte_w << len_sh);
                if (pos_reg >= 32'd3) begin
                    pos_next   = '0;
                    flen_next  = alen_next;
                    phase_next = (alen_next == '0) ? PH_COUNTER : PH_ACTOR;
                end else begin
                    pos_next = pos_reg + 32'd1;
                end
            end
            PH_NAME, PH_ELEM: begin
                pos_next = pos_reg + 32'd1;
                if (pos_next >= flen_reg) begin
                    pos_next   = '0;
                    phase_next = (ph == PH_NAME) ? PH_TYPE : PH_ACTORLEN;
                end
            end
            PH_TYPE: begin
                pos_next = '0;
                if (in_byte_reg inside {CHAR_CLOCK, CHAR_TOMBSTONE}) begin
                    type_next  = (in_byte_reg == CHAR_CLOCK) ? TYPE_CLOCK : TYPE_TOMBSTONE;
                    flen_next  = '0;
                    phase_next = PH_ACTOR;
                end else if (in_byte_reg == CHAR_ELEMENT) begin
                    type_next  = TYPE_ELEMENT;
                    phase_next = PH_ELEMLEN;
                end else begin
                    type_next  = (in_byte_reg == CHAR_END) ? TYPE_END : TYPE_INVALID;
                    phase_next = PH_IGNORED;
                end
            end
            PH_ACTOR: begin
                pos_next = pos_reg + 32'd1;
                if (type_reg == TYPE_ELEMENT) begin
                    if (pos_next >= flen_reg) begin
                        pos_next   = '0;
                        phase_next = PH_COUNTER;
                    end
                end else begin
                    // clock and tombstone keys: count the actor bytes
                    alen_next = alen_reg + 32'd1;
                end
            end
            PH_COUNTER: begin
                cnt_next = cnt_reg | ({56'd0, in_byte_reg} << cnt_sh);
                if (pos_reg >= 32'd7) begin
                    pos_next   = '0;
                    phase_next = PH_IGNORED;
                end else begin
                    pos_next = pos_reg + 32'd1;
                end
            end
            default: begin
                pos_next = pos_reg + 32'd1;
            end
        endcase

        if (type_next == TYPE_NONE) begin
            complete = 1'b0;
        end else if (type_next == TYPE_ELEMENT) begin
            complete = (phase_next == PH_IGNORED);
        end else begin
            complete = 1'b1;
        end

        result          = '0;
        result[3:0]     = ph;
        result[35:4]    = pos_reg;
        result[38:36]   = type_next;
        if (in_last_reg) begin
            result[39]      = !complete;
            result[71:40]   = nlen_next;
            result[103:72]  = elen_next;
            result[135:104] = alen_next;
            result[199:136] = cnt_next;
            // start the next key from scratch
            phase_next = PH_NAMELEN;
            pos_next   = '0;
            flen_next  = '0;
            cnt_next   = '0;
            type_next  = TYPE_NONE;
            nlen_next  = '0;
            elen_next  = '0;
            alen_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            phase_reg   <= PH_NAMELEN;
            pos_reg     <= '0;
            flen_reg    <= '0;
            cnt_reg     <= '0;
            type_reg    <= TYPE_NONE;
            nlen_reg    <= '0;
            elen_reg    <= '0;
            alen_reg    <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_vld_reg <= 1'b1;
            end else if (move) begin
                in_vld_reg <= 1'b0;
            end
            if (move) begin
                out_vld_reg <= 1'b1;
                phase_reg   <= phase_next;
                pos_reg     <= pos_next;
                flen_reg    <= flen_next;
                cnt_reg     <= cnt_next;
                type_reg    <= type_next;
                nlen_reg    <= nlen_next;
                elen_reg    <= elen_next;
                alen_reg    <= alen_next;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (move) begin
            out_data_reg <= result;
            out_last_reg <= in_last_reg;
        end
    end

`ifndef SYNTHESIS
    // a last byte always returns the parser to the start of a key
    assert property (@(posedge aclk) disable iff (!aresetn)
        (move && in_last_reg) |=> (phase_reg == PH_NAMELEN && pos_reg == '0
            && type_reg == TYPE_NONE))
        else $error("parser state not cleared after last byte");

    // summary fields are zero except on the last result of a key
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[RESULT_W-1:39] == '0))
        else $error("summary fields set on a result that is not last");

    // reported role never goes beyond the ignored code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:0] <= PH_IGNORED))
        else $error("byte role out of range");

    // phases past the type byte only occur once a type has been seen
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_ELEMLEN || phase_reg == PH_ELEM || phase_reg == PH_ACTORLEN
            || phase_reg == PH_ACTOR || phase_reg == PH_COUNTER) |-> (type_reg != TYPE_NONE))
        else $error("data phase entered without a type");
`endif

endmodule

FILE: tb/sv/set_key_field_parser_tb.sv
`timescale 1ns / 1ps

module set_key_field_parser_tb;
    import skfp_pkg::*;

    // Labels for one key byte, as the block should report them
    typedef struct packed {
        bit [3:0]  role;
        bit [31:0] offset;
        bit [2:0]  ktype;
        bit        done;
        bit        status;
        bit [31:0] name_len;
        bit [31:0] elem_len;
        bit [31:0] actor_len;
        bit [63:0] counter;
    } key_label_t;

    typedef struct packed {
        bit [7:0] data;
        bit       last;
        bit       wait_drain;
    } key_item_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = '0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [RESULT_W-1:0] m_tdata;
    logic                m_tlast;

    set_key_field_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    key_item_t  key_bytes_q[$];
    key_label_t pending_labels[$];
    bit [7:0]   key_build[$];
    key_item_t  tx_item;
    int         queued_total = 0;
    int         mismatches   = 0;
    int         tx_gap       = 0;
    int         rx_wait      = 0;
    int         rx_stall     = 0;
    int         rx_hold_req  = 0;
    bit         tx_idle_en   = 1'b1;
    bit         rx_idle_en   = 1'b1;

    // Parser state mirrored by the testbench
    bit [3:0]  ps_phase;
    bit [31:0] ps_pos;
    bit [31:0] ps_len;
    bit [63:0] ps_counter;
    bit [2:0]  ps_type;
    bit [31:0] ps_name_len;
    bit [31:0] ps_elem_len;
    bit [31:0] ps_actor_len;

    function automatic void reset_parser();
        ps_phase     = PH_NAMELEN;
        ps_pos       = '0;
        ps_len       = '0;
        ps_counter   = '0;
        ps_type      = TYPE_NONE;
        ps_name_len  = '0;
        ps_elem_len  = '0;
        ps_actor_len = '0;
    endfunction

    // Open a data field; an empty one is skipped straight to what follows it
    function automatic void enter_field(input bit [3:0] data_ph, input bit [3:0] after_ph,
                                        input bit [31:0] len);
        ps_pos   = '0;
        ps_len   = len;
        ps_phase = (len == 0) ? after_ph : data_ph;
    endfunction

    function automatic key_label_t label_key_byte(input bit [7:0] b, input bit last);
        key_label_t lbl;
        bit [3:0]   ph;
        bit         complete;
        lbl = '0;
        ph = (ps_phase > PH_IGNORED) ? PH_IGNORED : ps_phase;
        ps_phase = ph;
        lbl.role = ph;
        lbl.offset = ps_pos;
        case (ph)
            PH_NAMELEN: begin
                ps_name_len |= 32'(b) << (8 * ps_pos[1:0]);
                if (ps_pos >= 3) enter_field(PH_NAME, PH_TYPE, ps_name_len);
                else ps_pos++;
            end
            PH_ELEMLEN: begin
                ps_elem_len |= 32'(b) << (8 * ps_pos[1:0]);
                if (ps_pos >= 3) enter_field(PH_ELEM, PH_ACTORLEN, ps_elem_len);
                else ps_pos++;
            end
            PH_ACTORLEN: begin
                ps_actor_len |= 32'(b) << (8 * ps_pos[1:0]);
                if (ps_pos >= 3) enter_field(PH_ACTOR, PH_COUNTER, ps_actor_len);
                else ps_pos++;
            end
            PH_NAME, PH_ELEM: begin
                ps_pos++;
                if (ps_pos >= ps_len) begin
                    ps_pos = '0;
                    ps_phase = (ph == PH_NAME) ? PH_TYPE : PH_ACTORLEN;
                end
            end
            PH_TYPE: begin
                ps_pos = '0;
                if (b == CHAR_CLOCK || b == CHAR_TOMBSTONE) begin
                    ps_type = (b == CHAR_CLOCK) ? TYPE_CLOCK : TYPE_TOMBSTONE;
                    ps_len = '0;
                    ps_phase = PH_ACTOR;
                end else if (b == CHAR_ELEMENT) begin
                    ps_type = TYPE_ELEMENT;
                    ps_phase = PH_ELEMLEN;
                end else begin
                    ps_type = (b == CHAR_END) ? TYPE_END : TYPE_INVALID;
                    ps_phase = PH_IGNORED;
                end
            end
            PH_ACTOR: begin
                ps_pos++;
                // clock and tombstone keys count their actor bytes instead
                if (ps_type == TYPE_ELEMENT) begin
                    if (ps_pos >= ps_len) begin
                        ps_pos = '0;
                        ps_phase = PH_COUNTER;
                    end
                end else begin
                    ps_actor_len++;
                end
            end
            PH_COUNTER: begin
                ps_counter |= 64'(b) << (8 * ps_pos[2:0]);
                if (ps_pos >= 7) begin
                    ps_pos = '0;
                    ps_phase = PH_IGNORED;
                end else begin
                    ps_pos++;
                end
            end
            default: ps_pos++;
        endcase
        lbl.ktype = ps_type;
        if (last) begin
            if (ps_type == TYPE_ELEMENT) complete = (ps_phase == PH_IGNORED);
            else complete = (ps_type != TYPE_NONE);
            lbl.done      = 1'b1;
            lbl.status    = !complete;
            lbl.name_len  = ps_name_len;
            lbl.elem_len  = ps_elem_len;
            lbl.actor_len = ps_actor_len;
            lbl.counter   = ps_counter;
            reset_parser();
        end
        return lbl;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatches++;
        $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic append_le(input bit [63:0] v, input int n);
        for (int i = 0; i < n; i++) key_build.push_back(v[8*i +: 8]);
    endtask

    task automatic append_random(input int n);
        for (int i = 0; i < n; i++) key_build.push_back(8'($urandom_range(0, 255)));
    endtask

    // Move the key under construction onto the transfer queue
    task automatic queue_key(input bit drain);
        key_item_t it;
        for (int i = 0; i < key_build.size(); i++) begin
            it.data = key_build[i];
            it.last = (i == key_build.size() - 1);
            it.wait_drain = drain && (i == 0);
            key_bytes_q.push_back(it);
        end
        queued_total += key_build.size();
        key_build.delete();
    endtask

    task automatic make_random_key();
        int       kind;
        int       nlen;
        int       elen;
        int       alen;
        int       cut;
        bit [7:0] tb;
        kind = $urandom_range(0, 15);
        nlen = $urandom_range(0, 6);
        if (kind == 15) begin
            append_random($urandom_range(1, 8));
        end else if (kind == 14) begin
            // name length far beyond the key: always cut short
            append_le(64'({8'($urandom_range(1, 255)), 24'($urandom)}), 4);
            append_random($urandom_range(0, 6));
        end else begin
            append_le(64'(nlen), 4);
            append_random(nlen);
            if (kind <= 8) begin
                elen = $urandom_range(0, 6);
                alen = $urandom_range(0, 6);
                key_build.push_back(CHAR_ELEMENT);
                append_le(64'(elen), 4);
                append_random(elen);
                append_le(64'(alen), 4);
                append_random(alen);
                append_le({$urandom, $urandom}, 8);
                if ($urandom_range(0, 3) == 0) append_random($urandom_range(1, 3));
            end else if (kind <= 10) begin
                key_build.push_back(kind == 9 ? CHAR_CLOCK : CHAR_TOMBSTONE);
                append_random($urandom_range(0, 8));
            end else if (kind == 11) begin
                key_build.push_back(CHAR_END);
                append_random($urandom_range(0, 3));
            end else begin
                do tb = 8'($urandom_range(0, 255));
                while (tb == CHAR_CLOCK || tb == CHAR_TOMBSTONE || tb == CHAR_ELEMENT
                       || tb == CHAR_END);
                key_build.push_back(tb);
                append_random($urandom_range(0, 3));
            end
            if ($urandom_range(0, 7) == 0) begin
                cut = $urandom_range(1, key_build.size());
                while (key_build.size() > cut) void'(key_build.pop_back());
            end
        end
        queue_key($urandom_range(0, 11) == 0);
    endtask

    // Sender: offer queued key bytes, predict each accepted transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready)
                pending_labels.push_back(label_key_byte(s_tdata, s_tlast));
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (key_bytes_q.size() != 0 &&
                             (!key_bytes_q[0].wait_drain || pending_labels.size() == 0)) begin
                    tx_item = key_bytes_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= tx_item.data;
                    s_tlast  <= tx_item.last;
                    tx_gap = tx_idle_en ? $urandom_range(0, 5) : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each result transfer against the oldest label
    always @(posedge aclk) begin
        key_label_t want;
        bit         ready_nxt;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
            rx_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_labels.size() == 0) begin
                    flag_mismatch("unexpected result", m_tdata[63:0], '0);
                end else begin
                    want = pending_labels.pop_front();
                    if (m_tdata[3:0] !== want.role)
                        flag_mismatch("byte_role", 64'(m_tdata[3:0]), 64'(want.role));
                    if (m_tdata[35:4] !== want.offset)
                        flag_mismatch("byte_offset", 64'(m_tdata[35:4]), 64'(want.offset));
                    if (m_tdata[38:36] !== want.ktype)
                        flag_mismatch("key_type", 64'(m_tdata[38:36]), 64'(want.ktype));
                    if (m_tlast !== want.done)
                        flag_mismatch("key_done", 64'(m_tlast), 64'(want.done));
                    if (m_tdata[39] !== want.status)
                        flag_mismatch("key_status", 64'(m_tdata[39]), 64'(want.status));
                    if (m_tdata[71:40] !== want.name_len)
                        flag_mismatch("name_length", 64'(m_tdata[71:40]),
                                      64'(want.name_len));
                    if (m_tdata[103:72] !== want.elem_len)
                        flag_mismatch("element_length", 64'(m_tdata[103:72]),
                                      64'(want.elem_len));
                    if (m_tdata[135:104] !== want.actor_len)
                        flag_mismatch("actor_length", 64'(m_tdata[135:104]),
                                      64'(want.actor_len));
                    if (m_tdata[199:136] !== want.counter)
                        flag_mismatch("counter_value", m_tdata[199:136], want.counter);
                end
                rx_wait = rx_idle_en ? $urandom_range(0, 5) : 0;
            end
            if (rx_hold_req > 0) begin
                rx_stall = rx_hold_req;
                rx_hold_req = 0;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                ready_nxt = 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                ready_nxt = 1'b0;
            end else begin
                ready_nxt = 1'b1;
            end
            m_tready <= ready_nxt;
        end
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int target;
        reset_parser();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // element key with empty name, element and actor, all-ones counter
        append_le(64'd0, 4);
        key_build.push_back(CHAR_ELEMENT);
        append_le(64'd0, 4);
        append_le(64'd0, 4);
        append_le(64'hFFFF_FFFF_FFFF_FFFF, 8);
        queue_key(1'b0);
        // largest name length, cut inside the name
        append_le(64'h0000_0000_FFFF_FFFF, 4);
        key_build.push_back(8'hAA);
        queue_key(1'b0);
        // clock key with one actor byte, sent once everything has drained
        append_le(64'd0, 4);
        key_build.push_back(CHAR_CLOCK);
        key_build.push_back(8'h80);
        queue_key(1'b1);
        // invalid type followed by a trailing byte
        append_le(64'd0, 4);
        key_build.push_back(8'hFF);
        key_build.push_back(8'h00);
        queue_key(1'b0);
        // end key whose last byte is the type byte
        append_le(64'd1, 4);
        key_build.push_back(8'h7F);
        key_build.push_back(CHAR_END);
        queue_key(1'b0);
        while (key_bytes_q.size() != 0) @(posedge aclk);

        for (int ph = 0; ph < 8; ph++) begin
            tx_idle_en = (ph < 4) ? ph[0] : 1'($urandom_range(0, 1));
            rx_idle_en = (ph < 4) ? ph[1] : 1'($urandom_range(0, 1));
            target = queued_total + 140;
            while (queued_total < target) make_random_key();
            // hold the receiver off long enough for the block to back up
            if (ph == 2) rx_hold_req = 80;
            while (key_bytes_q.size() != 0) @(posedge aclk);
        end

        while (s_tvalid || pending_labels.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && pending_labels.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
